[design/spims_pkg.sv]
// Package for the SPI master shift engine: shared types, register map,
// reset values and small bit-manipulation helpers.
// No dependencies.
package spims_pkg;

    // Word limits
    localparam int MAX_WORD_BITS = 32;
    localparam int WORD_W        = 32;
    localparam int BITS_W        = 6;
    localparam int TICK_W        = 8;
    localparam int BYTES_W       = 3;
    localparam int MAX_BYTES     = 4;

    // APB register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_CPOL  = 3'd0,
        REG_CPHA  = 3'd1,
        REG_LSB   = 3'd2,
        REG_HALF  = 3'd3,
        REG_BYTES = 3'd4
    } spims_reg_t;

    // Register reset values
    localparam logic               CPOL_RESET  = 1'b0;
    localparam logic               CPHA_RESET  = 1'b0;
    localparam logic               LSB_RESET   = 1'b0;
    localparam logic [TICK_W-1:0]  HALF_RESET  = 8'd64;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 3'd1;

    typedef struct packed {
        logic               cpol;
        logic               cpha;
        logic               lsb_first;
        logic [TICK_W-1:0]  half_period;
        logic [BYTES_W-1:0] word_bytes;
    } spims_cfg_t;

    // Engine state carried from tick to tick
    typedef struct packed {
        logic [WORD_W-1:0] tx_shift;
        logic [WORD_W-1:0] rx_shift;
        logic [BITS_W-1:0] bits_left;
        logic [TICK_W-1:0] tick_count;
        logic              clock_level;
        logic              half_phase;
        logic              active;
    } spims_state_t;

    // One result beat
    typedef struct packed {
        logic              sck;
        logic              mosi;
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] rx_word;
    } spims_result_t;

    // Bit reversal, pure wiring
    function automatic logic [WORD_W-1:0] rev_word(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = v[WORD_W-1-i];
        end
        return r;
    endfunction

    // Transfer length in bits from the byte-count register
    function automatic logic [BITS_W-1:0] word_bits(input logic [BYTES_W-1:0] nbytes);
        logic [BYTES_W-1:0] b;
        logic [BITS_W-1:0]  n;
        b = nbytes;
        if (b == '0) begin
            b = BYTES_W'(1);
        end
        if (b > BYTES_W'(MAX_BYTES)) begin
            b = BYTES_W'(MAX_BYTES);
        end
        n = {b, 3'b000};
        if (n > BITS_W'(MAX_WORD_BITS)) begin
            n = BITS_W'(MAX_WORD_BITS);
        end
        return n;
    endfunction

    // Low n bits set
    function automatic logic [WORD_W-1:0] bit_mask(input logic [BITS_W-1:0] n);
        logic [WORD_W-1:0] m;
        if (n >= BITS_W'(WORD_W)) begin
            m = '1;
        end else begin
            m = (WORD_W'(1) << n) - WORD_W'(1);
        end
        return m;
    endfunction

endpackage

[design/spims_step.sv]
// One tick of the SPI shift engine: next state and result beat from the
// current state, configuration and input beat. Pure combinational.
// Depends on spims_pkg.
module spims_step (
    input  spims_pkg::spims_cfg_t    cfg,
    input  spims_pkg::spims_state_t  state_q,
    input  logic                     start_req,
    input  logic [31:0]              tx_word,
    input  logic                     miso_in,
    output spims_pkg::spims_state_t  state_d,
    output spims_pkg::spims_result_t result
);

    logic [spims_pkg::TICK_W-1:0] hp;
    logic [spims_pkg::TICK_W-1:0] tick_inc;
    logic [spims_pkg::BITS_W-1:0] nbits;
    logic [spims_pkg::BITS_W-1:0] pad;
    logic [spims_pkg::WORD_W-1:0] tx_masked;
    logic                         done;
    logic [spims_pkg::WORD_W-1:0] rx_out;

    // Zero half period runs as one tick
    assign hp        = (cfg.half_period == '0) ? spims_pkg::TICK_W'(1) : cfg.half_period;
    assign tick_inc  = state_q.tick_count + spims_pkg::TICK_W'(1);
    assign nbits     = spims_pkg::word_bits(cfg.word_bytes);
    assign pad       = spims_pkg::BITS_W'(spims_pkg::WORD_W) - nbits;
    assign tx_masked = tx_word & spims_pkg::bit_mask(nbits);

    // State update
    always_comb begin
        state_d = state_q;
        done    = 1'b0;
        rx_out  = '0;
        if (!state_q.active) begin
            if (start_req) begin
                state_d.tx_shift    = cfg.lsb_first ? spims_pkg::rev_word(tx_masked)
                                                    : (tx_masked << pad);
                state_d.rx_shift    = '0;
                state_d.bits_left   = nbits;
                state_d.tick_count  = '0;
                state_d.half_phase  = 1'b0;
                state_d.active      = 1'b1;
                state_d.clock_level = cfg.cpol ^ cfg.cpha;
            end
        end else if (tick_inc >= hp) begin
            state_d.tick_count = '0;
            if (!state_q.half_phase) begin
                // sample edge
                state_d.half_phase  = 1'b1;
                state_d.clock_level = ~state_q.clock_level;
                state_d.rx_shift    = {state_q.rx_shift[spims_pkg::WORD_W-2:0], miso_in};
            end else begin
                // end of bit
                state_d.tx_shift   = {state_q.tx_shift[spims_pkg::WORD_W-2:0], 1'b0};
                state_d.bits_left  = state_q.bits_left - spims_pkg::BITS_W'(1);
                state_d.half_phase = 1'b0;
                if (state_d.bits_left == '0) begin
                    state_d.active = 1'b0;
                    done           = 1'b1;
                    rx_out = cfg.lsb_first ? (spims_pkg::rev_word(state_q.rx_shift) >> pad)
                                           : (state_q.rx_shift & spims_pkg::bit_mask(nbits));
                end else begin
                    // trailing edge (phase 0) or next shift edge (phase 1)
                    state_d.clock_level = ~state_q.clock_level;
                end
            end
        end else begin
            state_d.tick_count = tick_inc;
        end
        // idle clock follows polarity
        if (!state_d.active) begin
            state_d.clock_level = cfg.cpol;
        end
    end

    // Result beat
    always_comb begin
        result.sck     = state_d.clock_level;
        result.mosi    = state_d.active & state_d.tx_shift[spims_pkg::WORD_W-1];
        result.busy    = state_d.active;
        result.done    = done;
        result.rx_word = rx_out;
    end

endmodule

[design/spi_master_shift_engine_core.sv]
// SPI master shift engine, modes 0 to 3, one engine tick per input beat.
// A result beat is registered and presented the cycle after its input beat is accepted.
// Throughput: one input beat per cycle unless m_valid is held by a low m_ready;
// the result register accepts the next beat while its current beat is taken in the same cycle.
// Reset (aresetn low, synchronous): engine idle, configuration registers at defaults, m_valid cleared.
// Depends on spims_pkg and spims_step.
module spi_master_shift_engine_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spims_pkg::ADDR_W-1:0]   paddr,
    input  logic [spims_pkg::DATA_W-1:0]   pwdata,
    output logic [spims_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_start_req,
    input  logic [31:0]                    s_tx_word,
    input  logic                           s_miso_in,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_sck_out,
    output logic                           m_mosi_out,
    output logic                           m_busy_res,
    output logic                           m_done_res,
    output logic [31:0]                    m_rx_word
);

    spims_pkg::spims_cfg_t    cfg_reg;
    spims_pkg::spims_state_t  state_reg;
    spims_pkg::spims_state_t  state_next;
    spims_pkg::spims_result_t result_next;
    spims_pkg::spims_result_t result_reg;
    logic                     m_valid_reg;
    logic                     cfg_wr;
    logic                     s_fire;
    spims_pkg::spims_reg_t    reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_sel = spims_pkg::spims_reg_t'(paddr[4:2]);
    assign s_ready = ~m_valid_reg | m_ready;
    assign s_fire  = s_valid & s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cpol        <= spims_pkg::CPOL_RESET;
            cfg_reg.cpha        <= spims_pkg::CPHA_RESET;
            cfg_reg.lsb_first   <= spims_pkg::LSB_RESET;
            cfg_reg.half_period <= spims_pkg::HALF_RESET;
            cfg_reg.word_bytes  <= spims_pkg::BYTES_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                spims_pkg::REG_CPOL:  cfg_reg.cpol        <= pwdata[0];
                spims_pkg::REG_CPHA:  cfg_reg.cpha        <= pwdata[0];
                spims_pkg::REG_LSB:   cfg_reg.lsb_first   <= pwdata[0];
                spims_pkg::REG_HALF:  cfg_reg.half_period <= pwdata[spims_pkg::TICK_W-1:0];
                spims_pkg::REG_BYTES: cfg_reg.word_bytes  <= pwdata[spims_pkg::BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            spims_pkg::REG_CPOL:  prdata[0] = cfg_reg.cpol;
            spims_pkg::REG_CPHA:  prdata[0] = cfg_reg.cpha;
            spims_pkg::REG_LSB:   prdata[0] = cfg_reg.lsb_first;
            spims_pkg::REG_HALF:  prdata[spims_pkg::TICK_W-1:0] = cfg_reg.half_period;
            spims_pkg::REG_BYTES: prdata[spims_pkg::BYTES_W-1:0] = cfg_reg.word_bytes;
            default: ;
        endcase
    end

    // Tick logic
    spims_step u_step (
        .cfg       (cfg_reg),
        .state_q   (state_reg),
        .start_req (s_start_req),
        .tx_word   (s_tx_word),
        .miso_in   (s_miso_in),
        .state_d   (state_next),
        .result    (result_next)
    );

    // Engine state advances on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.tx_shift    <= '0;
            state_reg.rx_shift    <= '0;
            state_reg.bits_left   <= '0;
            state_reg.tick_count  <= '0;
            state_reg.clock_level <= spims_pkg::CPOL_RESET;
            state_reg.half_phase  <= 1'b0;
            state_reg.active      <= 1'b0;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_sck_out  = result_reg.sck;
    assign m_mosi_out = result_reg.mosi;
    assign m_busy_res = result_reg.busy;
    assign m_done_res = result_reg.done;
    assign m_rx_word  = result_reg.rx_word;

    // Checks
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done beat reported busy");

    a_idle_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> !m_mosi_out && (m_sck_out == cfg_reg.cpol))
        else $error("idle beat with active serial lines");

    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.active |-> !state_reg.half_phase)
        else $error("half phase set while idle");

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bits_left <= spims_pkg::BITS_W'(spims_pkg::MAX_WORD_BITS))
        else $error("bit count out of range");

endmodule
